// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

   // Fixed sizes of the data path.
   localparam int BYTE_W      = 8;
   localparam int STORE_DEPTH = 8;
   localparam int PLEN_W      = 4;
   localparam int RLEN_W      = 4;
   localparam int TEXT_W      = STORE_DEPTH * BYTE_W;
   localparam int CNT_W       = 4;
   localparam int QUEUE_DEPTH = 4;

   // Defaults for the top-level parameters.
   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACE_MAX_DEF = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd3;

   // One queued command: up to eight bytes to send, how many, and whether the
   // request closed the text. A zero count with last set is a bare end marker.
   typedef struct packed {
      logic [STORE_DEPTH-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                   count;
      logic                               last;
   } cmd_type;

endpackage

// ===== rtl/sfr_front.sv =====
module sfr_front #(
   parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            req_in_last,
   input  logic                            csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            queue_full,
   output logic                            push,
   output sfr_pkg::cmd_type                push_cmd
);

   localparam int WIN_DEPTH = (PATTERN_MAX < sfr_pkg::STORE_DEPTH) ?
                              PATTERN_MAX : sfr_pkg::STORE_DEPTH;
   localparam int REP_CAP   = (REPLACE_MAX < sfr_pkg::STORE_DEPTH) ?
                              REPLACE_MAX : sfr_pkg::STORE_DEPTH;
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

   logic [sfr_pkg::PLEN_W-1:0] plen_ff, plen_in;
   logic [sfr_pkg::TEXT_W-1:0] pat_ff, pat_in;
   logic [sfr_pkg::RLEN_W-1:0] rlen_ff, rlen_in;
   logic [sfr_pkg::TEXT_W-1:0] rep_ff, rep_in;

   logic [WIN_DEPTH-1:0][sfr_pkg::BYTE_W-1:0] win_ff, win_in;
   logic [FILL_W-1:0]                          fill_ff, fill_in;

   logic                                            accept;
   logic                                            cfg_hit;
   logic [sfr_pkg::PLEN_W-1:0]                      plen_eff;
   logic [sfr_pkg::RLEN_W-1:0]                      rlen_eff;
   logic [sfr_pkg::PLEN_W-1:0]                      fill_plus;
   logic                                            full;
   logic                                            mism;
   logic [sfr_pkg::STORE_DEPTH-1:0][sfr_pkg::BYTE_W-1:0] cand;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign cfg_hit   = csr_write && (csr_index <= sfr_pkg::REG_REPLACEMENT_BYTES);

   // Configuration registers.
   always_comb begin
      plen_in = plen_ff;
      pat_in  = pat_ff;
      rlen_in = rlen_ff;
      rep_in  = rep_ff;
      if (csr_write) begin
         case (csr_index)
            sfr_pkg::REG_PATTERN_LENGTH:     plen_in = csr_data[sfr_pkg::PLEN_W-1:0];
            sfr_pkg::REG_PATTERN_BYTES:      pat_in  = csr_data[sfr_pkg::TEXT_W-1:0];
            sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_in = csr_data[sfr_pkg::RLEN_W-1:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  rep_in  = csr_data[sfr_pkg::TEXT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective lengths: a zero pattern length counts as one, and both lengths
   // saturate at what the window and the command can hold.
   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = sfr_pkg::PLEN_W'(1);
      end else if (plen_ff > sfr_pkg::PLEN_W'(WIN_DEPTH)) begin
         plen_eff = sfr_pkg::PLEN_W'(WIN_DEPTH);
      end else begin
         plen_eff = plen_ff;
      end
      if (rlen_ff > sfr_pkg::RLEN_W'(REP_CAP)) begin
         rlen_eff = sfr_pkg::RLEN_W'(REP_CAP);
      end else begin
         rlen_eff = rlen_ff;
      end
   end

   // Window with the new byte placed after the held ones, and the compare.
   always_comb begin
      cand = '0;
      mism = 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         cand[i] = (fill_ff == FILL_W'(i)) ? req_in_byte : win_ff[i];
      end
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if ((sfr_pkg::PLEN_W'(i) < plen_eff) &&
             (cand[i] != pat_ff[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])) begin
            mism = 1'b1;
         end
      end
   end

   assign fill_plus = sfr_pkg::PLEN_W'(fill_ff) + sfr_pkg::PLEN_W'(1);
   assign full      = (fill_plus == plen_eff);

   // Classify the request into one command and update the window.
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      push_cmd = '0;
      push     = 1'b0;
      if (accept) begin
         push_cmd.last = req_in_last;
         if (full && !mism) begin
            // Match: send the replacement and empty the window.
            push_cmd.bytes = rep_ff;
            push_cmd.count = sfr_pkg::CNT_W'(rlen_eff);
            fill_in        = '0;
         end else if (full) begin
            // Mismatch: send the oldest byte, or the whole window at the end.
            push_cmd.bytes = cand;
            if (req_in_last) begin
               push_cmd.count = sfr_pkg::CNT_W'(plen_eff);
               fill_in        = '0;
            end else begin
               push_cmd.count = sfr_pkg::CNT_W'(1);
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_in[i] = cand[i+1];
               end
               fill_in = FILL_W'(plen_eff - sfr_pkg::PLEN_W'(1));
            end
         end else begin
            // Window not yet full: hold the byte, or flush all at the end.
            push_cmd.bytes = cand;
            if (req_in_last) begin
               push_cmd.count = sfr_pkg::CNT_W'(fill_plus);
               fill_in        = '0;
            end else begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  win_in[i] = cand[i];
               end
               fill_in = FILL_W'(fill_plus);
            end
         end
         push = (push_cmd.count != '0) || req_in_last;
      end
      if (cfg_hit) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= sfr_pkg::PLEN_W'(1);
         pat_ff  <= '0;
         rlen_ff <= '0;
         rep_ff  <= '0;
         fill_ff <= '0;
      end else begin
         plen_ff <= plen_in;
         pat_ff  <= pat_in;
         rlen_ff <= rlen_in;
         rep_ff  <= rep_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

`ifndef SYNTHESIS
   a_fill_below_plen: assert property (@(posedge clock) disable iff (reset)
      sfr_pkg::PLEN_W'(fill_ff) < plen_eff)
      else $error("window holds a full pattern between requests");
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (fill_ff == '0))
      else $error("register write did not empty the window");
`endif

endmodule

// ===== rtl/sfr_queue.sv =====
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::cmd_type push_cmd,
   input  logic             pop,
   output sfr_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   localparam int DEPTH = sfr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfr_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command popped from an empty queue");
`endif

endmodule

// ===== rtl/sfr_back.sv =====
module sfr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::cmd_type            head,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_has_byte,
   output logic                        rsp_out_last
);

   localparam int D = sfr_pkg::STORE_DEPTH;

   logic                                busy_ff, busy_in;
   logic [sfr_pkg::CNT_W-1:0]           rem_ff, rem_in;
   logic [D-1:0][sfr_pkg::BYTE_W-1:0]   cur_ff, cur_in;
   logic                                cur_last_ff, cur_last_in;

   logic                                out_valid_ff, out_valid_in;
   logic [sfr_pkg::BYTE_W-1:0]          out_byte_ff, out_byte_in;
   logic                                out_has_ff, out_has_in;
   logic                                out_last_ff, out_last_in;

   logic                                can_load;

   assign can_load     = !out_valid_ff || !rsp_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_has_byte = out_has_ff;
   assign rsp_out_last = out_last_ff;

   // Serialize commands into the output register, one result per cycle unless stalled.
   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      cur_last_in  = cur_last_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (can_load) begin
         if (busy_ff) begin
            // Continue the command in progress.
            out_valid_in = 1'b1;
            out_byte_in  = cur_ff[0];
            out_has_in   = 1'b1;
            out_last_in  = cur_last_ff && (rem_ff == sfr_pkg::CNT_W'(1));
            for (int i = 0; i < D - 1; i++) begin
               cur_in[i] = cur_ff[i+1];
            end
            rem_in  = rem_ff - sfr_pkg::CNT_W'(1);
            busy_in = (rem_ff != sfr_pkg::CNT_W'(1));
         end else if (!empty) begin
            // Start a new command straight from the queue head.
            pop          = 1'b1;
            out_valid_in = 1'b1;
            cur_last_in  = head.last;
            if (head.count == '0) begin
               out_byte_in = '0;
               out_has_in  = 1'b0;
               out_last_in = 1'b1;
               busy_in     = 1'b0;
            end else begin
               out_byte_in = head.bytes[0];
               out_has_in  = 1'b1;
               out_last_in = head.last && (head.count == sfr_pkg::CNT_W'(1));
               for (int i = 0; i < D - 1; i++) begin
                  cur_in[i] = head.bytes[i+1];
               end
               rem_in  = head.count - sfr_pkg::CNT_W'(1);
               busy_in = (head.count != sfr_pkg::CNT_W'(1));
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      cur_ff      <= cur_in;
      cur_last_ff <= cur_last_in;
      out_byte_ff <= out_byte_in;
      out_has_ff  <= out_has_in;
      out_last_ff <= out_last_in;
   end

`ifndef SYNTHESIS
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_has_ff) |-> out_last_ff)
      else $error("end marker without the last flag");
   a_busy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff != '0))
      else $error("serializer busy with no bytes left");
`endif

endmodule

// ===== rtl/stream_find_replace.sv =====
// Streaming find-and-replace on a byte stream.
// Requests arrive on req_valid/req_stall, one text byte each, with
// req_in_last marking the final byte of a text. Every leftmost,
// non-overlapping occurrence of the pattern is replaced by the replacement;
// results leave on rsp_valid/rsp_stall, one byte each, with rsp_out_last on
// the final result of a text. A text whose end leaves nothing to send gets a
// single result with rsp_has_byte low.
// The csr_ port writes pattern and replacement; a write to a known register
// empties the lookahead window. Write only while the block is idle.
// A request's first result passes the command queue and the output register
// before it reaches the ports. The front takes one request per cycle unless
// stalled; the back sends one result per cycle unless stalled, so a request
// producing k results holds the back until all k are sent, and a four-entry
// command queue between them lets the front keep accepting meanwhile.
// req_stall rises only when that queue is full. A stall on rsp_stall holds
// the result register and, through the queue, eventually the input.
// Reset clears the window, the queue and the output register and sets the
// registers to pattern length one, everything else zero.
module stream_find_replace #(
   parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            req_in_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_has_byte,
   output logic                            rsp_out_last,
   input  logic                            csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic             push;
   sfr_pkg::cmd_type push_cmd;
   logic             pop;
   sfr_pkg::cmd_type head;
   logic             queue_full;
   logic             queue_empty;

   sfr_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   sfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (queue_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== tb/sv/sfr_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and register ports of the find-and-replace block,
// predicts the result stream and compares what leaves the block against it.
module sfr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            req_in_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                            rsp_has_byte,
   input  logic                            rsp_out_last,
   input  logic                            csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              mismatches,
   output int                              owed
);

   localparam int PAT_CAP = (sfr_pkg::PATTERN_MAX_DEF < sfr_pkg::STORE_DEPTH) ?
                            sfr_pkg::PATTERN_MAX_DEF : sfr_pkg::STORE_DEPTH;
   localparam int REP_CAP = (sfr_pkg::REPLACE_MAX_DEF < 8) ? sfr_pkg::REPLACE_MAX_DEF : 8;

   typedef struct packed {
      logic [sfr_pkg::BYTE_W-1:0] out_byte;
      logic                       has_byte;
      logic                       out_last;
   } text_out_type;

   // Shadow copy of the registers and of the lookahead window.
   logic [sfr_pkg::PLEN_W-1:0]     pat_len;
   logic [sfr_pkg::CSR_DATA_W-1:0] pat_bytes;
   logic [sfr_pkg::RLEN_W-1:0]     rep_len;
   logic [sfr_pkg::CSR_DATA_W-1:0] rep_bytes;
   logic [sfr_pkg::BYTE_W-1:0]     window [sfr_pkg::STORE_DEPTH];
   int unsigned                    win_fill;

   // Result bytes the block still owes, oldest first.
   text_out_type owed_bytes[$];
   text_out_type want;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Advances the window by one request byte and queues the bytes it releases.
   function automatic void find_replace_step(input logic [sfr_pkg::BYTE_W-1:0] b,
                                             input logic lst);
      text_out_type step_out[$];
      int unsigned  plen;
      int unsigned  rlen;
      int unsigned  i;
      logic         hit;
      plen = (pat_len == '0) ? 1 : pat_len;
      if (plen > PAT_CAP) plen = PAT_CAP;
      rlen = (rep_len > REP_CAP) ? REP_CAP : rep_len;
      if (win_fill >= sfr_pkg::STORE_DEPTH) win_fill = sfr_pkg::STORE_DEPTH - 1;
      window[win_fill] = b;
      win_fill++;

      // A full window is either replaced whole or gives up its oldest byte.
      if (win_fill >= plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++) begin
            if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < rlen; i++) begin
               step_out.push_back('{rep_bytes[8*i +: 8], 1'b1, 1'b0});
            end
            win_fill = 0;
         end else begin
            step_out.push_back('{window[0], 1'b1, 1'b0});
            for (i = 1; i < win_fill; i++) window[i-1] = window[i];
            win_fill--;
         end
      end

      // The end of a text flushes the window; an empty end still gives a marker.
      if (lst) begin
         for (i = 0; i < win_fill; i++) begin
            step_out.push_back('{window[i], 1'b1, 1'b0});
         end
         win_fill = 0;
         if (step_out.size() == 0) step_out.push_back('{'0, 1'b0, 1'b0});
         step_out[step_out.size()-1].out_last = 1'b1;
      end

      foreach (step_out[k]) owed_bytes.push_back(step_out[k]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pat_len    = sfr_pkg::PLEN_W'(1);
         pat_bytes  = '0;
         rep_len    = '0;
         rep_bytes  = '0;
         win_fill   = 0;
         mismatches = 0;
         owed_bytes.delete();
      end else begin
         // Any known register write empties the window; unknown indexes do nothing.
         if (csr_write) begin
            case (csr_index)
               sfr_pkg::REG_PATTERN_LENGTH: begin
                  pat_len  = csr_data[sfr_pkg::PLEN_W-1:0];
                  win_fill = 0;
               end
               sfr_pkg::REG_PATTERN_BYTES: begin
                  pat_bytes = csr_data;
                  win_fill  = 0;
               end
               sfr_pkg::REG_REPLACEMENT_LENGTH: begin
                  rep_len  = csr_data[sfr_pkg::RLEN_W-1:0];
                  win_fill = 0;
               end
               sfr_pkg::REG_REPLACEMENT_BYTES: begin
                  rep_bytes = csr_data;
                  win_fill  = 0;
               end
               default: begin
               end
            endcase
         end

         if (req_valid && !req_stall) find_replace_step(req_in_byte, req_in_last);

         // Each accepted result must match the oldest owed one.
         if (rsp_valid && !rsp_stall) begin
            if (owed_bytes.size() == 0) begin
               report_mismatch($sformatf("result %h/%b/%b with nothing owed",
                                         rsp_out_byte, rsp_has_byte, rsp_out_last));
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_has_byte !== want.has_byte)
                  report_mismatch($sformatf("has_byte %b, expected %b",
                                            rsp_has_byte, want.has_byte));
               if (rsp_out_last !== want.out_last)
                  report_mismatch($sformatf("out_last %b, expected %b",
                                            rsp_out_last, want.out_last));
            end
         end
      end
      owed = owed_bytes.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int DRAIN_CYCLES = 8;
   localparam logic [sfr_pkg::CSR_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;
   localparam logic [sfr_pkg::CSR_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [sfr_pkg::BYTE_W-1:0]     req_in_byte = '0;
   logic                           req_in_last = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [sfr_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                           rsp_has_byte;
   logic                           rsp_out_last;
   logic                           csr_write = 1'b0;
   logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int mismatches;
   int owed;

   // Traffic shaping, in percent.
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned requests_sent = 0;

   // Alphabet and pattern of the current setting, used to build matching texts.
   logic [sfr_pkg::BYTE_W-1:0] letters [3];
   logic [sfr_pkg::BYTE_W-1:0] pat_seq [sfr_pkg::STORE_DEPTH];
   int unsigned                eff_len = 1;

   stream_find_replace dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   sfr_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .owed         (owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Offers one request byte, possibly after an idle gap, and returns at the
   // edge that takes it.
   task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic lst);
      if ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= lst;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      requests_sent++;
   endtask

   // Stops sending and waits until every owed result has left the block.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Holds one register write for one edge; the caller lowers csr_write.
   task automatic write_reg(input logic [sfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfr_pkg::CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [sfr_pkg::PLEN_W-1:0] plen,
                             input logic [63:0] pbytes,
                             input logic [sfr_pkg::RLEN_W-1:0] rlen,
                             input logic [63:0] rbytes);
      wait_idle();
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
      write_reg(sfr_pkg::REG_PATTERN_BYTES, pbytes);
      write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rbytes);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic [sfr_pkg::BYTE_W-1:0]    text_q[$];
      logic [sfr_pkg::PLEN_W-1:0]    plen;
      logic [sfr_pkg::RLEN_W-1:0]    rlen;
      logic [63:0]                   pbytes;
      logic [sfr_pkg::CSR_IDX_W-1:0] idx;
      int unsigned                   phase_end;
      int unsigned                   len;
      int unsigned                   r;
      int unsigned                   cut;
      int unsigned                   mid_at;
      int unsigned                   k;
      int unsigned                   j;
      int                            ph;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: a one-byte zero pattern deleted on match. A text that is
      // just the pattern leaves only the bare end marker.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);

      // Three-byte pattern, two-byte replacement, partial match flushed at the end.
      set_config(4'd3, 64'h0000_0000_0063_6261, 4'd2, 64'h0000_0000_0000_5859);
      send_byte(8'h78, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);

      // Pattern length zero acts as one; an oversized replacement length caps at eight.
      set_config(4'd0, 64'hFFFF_FFFF_FFFF_FF00, 4'd15, 64'h0123_4567_89AB_CDEF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // Oversized pattern length caps at eight. Writes to unknown indexes leave
      // the window alone, so the full pattern still matches across them.
      set_config(4'd15, 64'hFEDC_BA98_7654_3210, 4'd8, 64'h0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h32, 1'b0);
      wait_idle();
      write_reg(REG_UNUSED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_UNUSED_LAST, 64'h5555_5555_5555_5555);
      csr_write <= 1'b0;
      send_byte(8'h54, 1'b0);
      send_byte(8'h76, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'hBA, 1'b0);
      send_byte(8'hDC, 1'b0);
      send_byte(8'hFE, 1'b1);

      // A real register write mid-text discards what the window held.
      send_byte(8'h10, 1'b0);
      wait_idle();
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
      csr_write <= 1'b0;
      send_byte(8'h99, 1'b1);

      // Random texts in three traffic phases.
      for (ph = 0; ph < 3; ph++) begin
         send_gap_pct = (ph == 0) ? 16 : (ph == 1) ? 49 : 0;
         stall_pct    = (ph == 0) ? 49 : (ph == 1) ? 16 : 0;
         phase_end    = requests_sent + 100;
         while (requests_sent < phase_end) begin
            // New setting: a small alphabet so that texts hit the pattern often.
            if ($urandom_range(3, 0) == 0) begin
               letters[0] = 8'h00;
               letters[1] = 8'hFF;
            end else begin
               letters[0] = sfr_pkg::BYTE_W'($urandom_range(255, 0));
               letters[1] = sfr_pkg::BYTE_W'($urandom_range(255, 0));
            end
            letters[2] = sfr_pkg::BYTE_W'($urandom_range(255, 0));
            plen = sfr_pkg::PLEN_W'(($urandom_range(7, 0) == 0) ?
                                    $urandom_range(15, 0) : $urandom_range(4, 1));
            eff_len = (plen == 0) ? 1 : (plen > 8) ? 8 : plen;
            for (k = 0; k < sfr_pkg::STORE_DEPTH; k++) begin
               pat_seq[k] = letters[$urandom_range(2, 0)];
               pbytes[8*k +: 8] = pat_seq[k];
            end
            rlen = sfr_pkg::RLEN_W'(($urandom_range(7, 0) == 0) ?
                                    $urandom_range(15, 9) : $urandom_range(8, 0));
            set_config(plen, pbytes, rlen, {$urandom, $urandom});

            repeat ($urandom_range(5, 2)) begin
               // Build a text from whole patterns, broken prefixes and loose bytes.
               text_q.delete();
               len = $urandom_range(12, 1);
               while (text_q.size() < len) begin
                  r = $urandom_range(99, 0);
                  if (r < 35) begin
                     for (j = 0; j < eff_len; j++) text_q.push_back(pat_seq[j]);
                  end else if (r < 45) begin
                     cut = $urandom_range(eff_len - 1, 0);
                     for (j = 0; j < cut; j++) text_q.push_back(pat_seq[j]);
                     text_q.push_back(sfr_pkg::BYTE_W'($urandom_range(255, 0)));
                  end else if (r < 85) begin
                     text_q.push_back(letters[$urandom_range(2, 0)]);
                  end else begin
                     text_q.push_back(sfr_pkg::BYTE_W'($urandom_range(255, 0)));
                  end
               end

               // Now and then a register write lands in the middle of the text.
               mid_at = ($urandom_range(19, 0) == 0) ?
                        $urandom_range(text_q.size() - 1, 0) : text_q.size();
               for (k = 0; k < text_q.size(); k++) begin
                  if (k == mid_at) begin
                     wait_idle();
                     if ($urandom_range(1, 0) == 1) begin
                        idx = sfr_pkg::REG_REPLACEMENT_BYTES;
                     end else begin
                        idx = sfr_pkg::CSR_IDX_W'(REG_UNUSED_FIRST + $urandom_range(3, 0));
                     end
                     write_reg(idx, {$urandom, $urandom});
                     csr_write <= 1'b0;
                  end
                  send_byte(text_q[k], k == text_q.size() - 1);
               end
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
